// ===== rtl/trm_pkg.sv =====
`default_nettype none

package trm_pkg;

    localparam int LEN_W  = 12;
    localparam int COL_W  = 12;
    localparam int CHAR_W = 8;
    localparam int KIND_W = 4;
    localparam int RCOL_W = 13;
    localparam int CIDX_W = 3;
    localparam int CFG_W  = 13;

    // rule kinds
    localparam logic [KIND_W-1:0] RK_CHAR     = 4'd0;
    localparam logic [KIND_W-1:0] RK_TWO      = 4'd1;
    localparam logic [KIND_W-1:0] RK_IDENT    = 4'd2;
    localparam logic [KIND_W-1:0] RK_SPACES   = 4'd3;
    localparam logic [KIND_W-1:0] RK_FLOAT    = 4'd4;
    localparam logic [KIND_W-1:0] RK_INT      = 4'd5;
    localparam logic [KIND_W-1:0] RK_CCHAR    = 4'd6;
    localparam logic [KIND_W-1:0] RK_HEX      = 4'd7;
    localparam logic [KIND_W-1:0] RK_OCT      = 4'd8;
    localparam logic [KIND_W-1:0] RK_ESCAPE   = 4'd9;
    localparam logic [KIND_W-1:0] RK_RANGE    = 4'd10;
    localparam logic [KIND_W-1:0] RK_LINECONT = 4'd11;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_RULE_KIND  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_CHAR_ONE   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_CHAR_TWO   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_FIRST_NS   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_REQ_COLUMN = 3'd4;

    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_E_LO   = 8'h65;
    localparam logic [CHAR_W-1:0] CH_E_UP   = 8'h45;
    localparam logic [CHAR_W-1:0] CH_X_LO   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_X_UP   = 8'h58;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_octal(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_hex(input logic [CHAR_W-1:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_ident(input logic [CHAR_W-1:0] c);
        return is_letter(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    // escape letters: a b e f n r t v " ' ? backslash
    function automatic logic is_control(input logic [CHAR_W-1:0] c);
        return (c == 8'h61) || (c == 8'h62) || (c == 8'h65) || (c == 8'h66) ||
               (c == 8'h6E) || (c == 8'h72) || (c == 8'h74) || (c == 8'h76) ||
               (c == 8'h22) || (c == CH_QUOTE) || (c == 8'h3F) || (c == CH_BSLASH);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/trm_if.sv =====
`default_nettype none

interface trm_text_if
    import trm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              starts_match;
    logic              ends_text;
    logic [COL_W-1:0]  start_column;
    logic              line_starts_with_space;

    modport source (output valid, char_code, starts_match, ends_text, start_column,
                    line_starts_with_space, input ready);
    modport sink   (input valid, char_code, starts_match, ends_text, start_column,
                    line_starts_with_space, output ready);
endinterface

interface trm_result_if
    import trm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] match_length;
    logic             matched;

    modport source (output valid, match_length, matched, input ready);
    modport sink   (input valid, match_length, matched, output ready);
endinterface

`default_nettype wire

// ===== rtl/token_rule_matcher_core.sv =====
// channel     dir  payload
// text        in   char_code, starts_match, ends_text, start_column, line_starts_with_space
// result      out  match_length, matched
// cfg_*       in   write port: cfg_wr_en, cfg_index, cfg_wr_data
//
// One character per cycle; the result register is loaded in the cycle the
// deciding character is accepted and shows it the next cycle.
// text.ready is low only while a result is held and result.ready is low.
// Reset: idle and waiting for a start; rule_kind 0, required_column -1.
// Lengths saturate at min(MAX_MATCH_LEN, 4095).
`default_nettype none

module token_rule_matcher_core
    import trm_pkg::*;
#(
    parameter int MAX_MATCH_LEN = 4095
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    trm_text_if.sink               text,
    trm_result_if.source           result,
    input  wire logic              cfg_wr_en,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wr_data
);

    localparam int LEN_CAP = (MAX_MATCH_LEN < 4095) ? MAX_MATCH_LEN : 4095;
    localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);

    typedef enum logic [4:0] {
        PH_IDLE, PH_TWO, PH_IDENT, PH_SPACE, PH_FL_INT, PH_FL_FRAC, PH_FL_E,
        PH_FL_SIGN, PH_FL_EXP, PH_INT, PH_CC_OPEN, PH_CC_ESC, PH_CC_HEX,
        PH_CC_OCT, PH_CC_CLOSE, PH_HX_X, PH_HX_D, PH_HX_RUN, PH_OC_D,
        PH_OC_RUN, PH_SE_ESC, PH_SE_HEX, PH_SE_OCT, PH_RANGE
    } phase_t;

    logic [KIND_W-1:0] rule_kind_reg;
    logic [CHAR_W-1:0] char_one_reg;
    logic [CHAR_W-1:0] char_two_reg;
    logic              first_ns_reg;
    logic [RCOL_W-1:0] req_col_reg;

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  scanned_reg, scanned_next;
    logic [LEN_W-1:0]  acc_reg, acc_next;
    logic [1:0]        digit_reg, digit_next;
    logic              decided_reg, decided_next;

    logic              out_valid_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_matched_reg;

    logic              in_acc;
    logic              emit;
    logic              cont;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  prev_len;
    logic [LEN_W-1:0]  now_len;
    logic [1:0]        dig_inc;
    logic [CHAR_W-1:0] c;
    logic              gate_fail;

    assign in_acc      = text.valid && text.ready;
    assign text.ready  = !out_valid_reg || result.ready;
    assign c           = text.char_code;
    assign prev_len    = scanned_reg;
    assign now_len     = (scanned_reg < LEN_CAP_V) ? scanned_reg + 1'b1 : scanned_reg;
    assign dig_inc     = digit_reg + 2'd1;
    assign gate_fail   = (first_ns_reg && ((text.start_column != '0) ||
                                           text.line_starts_with_space)) ||
                         (!req_col_reg[RCOL_W-1] &&
                          (text.start_column != req_col_reg[COL_W-1:0]));

    always_comb
    begin
        phase_next   = phase_reg;
        scanned_next = scanned_reg;
        acc_next     = acc_reg;
        digit_next   = digit_reg;
        decided_next = decided_reg;
        emit         = 1'b0;
        cont         = 1'b0;
        len          = '0;

        if (text.starts_match)
        begin
            phase_next   = PH_IDLE;
            scanned_next = LEN_W'(1);
            acc_next     = '0;
            digit_next   = '0;
            decided_next = 1'b0;
            if (gate_fail)
            begin
                emit = 1'b1;
            end
            else
            begin
                unique case (rule_kind_reg)
                    RK_CHAR:
                    begin
                        emit = 1'b1;
                        len  = (c == char_one_reg) ? LEN_W'(1) : '0;
                    end
                    RK_TWO:
                    begin
                        if (c == char_one_reg) begin cont = 1'b1; phase_next = PH_TWO; end
                        else emit = 1'b1;
                    end
                    RK_IDENT:
                    begin
                        if (is_letter(c) || c == CH_UNDER)
                        begin
                            cont = 1'b1; phase_next = PH_IDENT;
                        end
                        else emit = 1'b1;
                    end
                    RK_SPACES:
                    begin
                        if (is_space(c)) begin cont = 1'b1; phase_next = PH_SPACE; end
                        else emit = 1'b1;
                    end
                    RK_FLOAT:
                    begin
                        if (is_digit(c)) begin cont = 1'b1; phase_next = PH_FL_INT; end
                        else if (c == CH_DOT) begin cont = 1'b1; phase_next = PH_FL_FRAC; end
                        else emit = 1'b1;
                    end
                    RK_INT:
                    begin
                        if (is_digit(c)) begin cont = 1'b1; phase_next = PH_INT; end
                        else emit = 1'b1;
                    end
                    RK_CCHAR:
                    begin
                        if (c == CH_QUOTE) begin cont = 1'b1; phase_next = PH_CC_OPEN; end
                        else emit = 1'b1;
                    end
                    RK_HEX:
                    begin
                        if (c == CH_ZERO) begin cont = 1'b1; phase_next = PH_HX_X; end
                        else emit = 1'b1;
                    end
                    RK_OCT:
                    begin
                        if (c == CH_ZERO) begin cont = 1'b1; phase_next = PH_OC_D; end
                        else emit = 1'b1;
                    end
                    RK_ESCAPE:
                    begin
                        if (c == CH_BSLASH) begin cont = 1'b1; phase_next = PH_SE_ESC; end
                        else emit = 1'b1;
                    end
                    RK_RANGE:
                    begin
                        if (c == char_one_reg) begin cont = 1'b1; phase_next = PH_RANGE; end
                        else emit = 1'b1;
                    end
                    RK_LINECONT:
                    begin
                        emit = 1'b1;
                        len  = (c == char_one_reg && text.ends_text) ? LEN_W'(1) : '0;
                    end
                    default: emit = 1'b1;
                endcase
            end
        end
        else if (!decided_reg)
        begin
            scanned_next = now_len;
            unique case (phase_reg)
                PH_TWO:
                begin
                    emit = 1'b1;
                    len  = (c == char_two_reg) ? now_len : '0;
                end
                PH_IDENT:
                begin
                    if (is_ident(c)) cont = 1'b1;
                    else begin emit = 1'b1; len = prev_len; end
                end
                PH_SPACE:
                begin
                    if (is_space(c)) cont = 1'b1;
                    else begin emit = 1'b1; len = prev_len; end
                end
                PH_FL_INT:
                begin
                    if (is_digit(c)) cont = 1'b1;
                    else if (c == CH_DOT) begin cont = 1'b1; phase_next = PH_FL_FRAC; end
                    else emit = 1'b1;
                end
                PH_FL_FRAC:
                begin
                    if (is_digit(c)) cont = 1'b1;
                    else if (prev_len == LEN_W'(1)) emit = 1'b1;
                    else if (c == CH_E_LO || c == CH_E_UP)
                    begin
                        cont = 1'b1; acc_next = prev_len; phase_next = PH_FL_E;
                    end
                    else begin emit = 1'b1; len = prev_len; end
                end
                PH_FL_E:
                begin
                    if (c == CH_PLUS || c == CH_MINUS) begin cont = 1'b1; phase_next = PH_FL_SIGN; end
                    else if (is_digit(c)) begin cont = 1'b1; phase_next = PH_FL_EXP; end
                    else begin emit = 1'b1; len = acc_reg; end
                end
                PH_FL_SIGN:
                begin
                    if (is_digit(c)) begin cont = 1'b1; phase_next = PH_FL_EXP; end
                    else begin emit = 1'b1; len = acc_reg; end
                end
                PH_FL_EXP, PH_INT:
                begin
                    if (is_digit(c)) cont = 1'b1;
                    else begin emit = 1'b1; len = prev_len; end
                end
                PH_CC_OPEN:
                begin
                    if (c == CH_QUOTE) emit = 1'b1;
                    else if (c == CH_BSLASH) begin cont = 1'b1; phase_next = PH_CC_ESC; end
                    else begin cont = 1'b1; phase_next = PH_CC_CLOSE; end
                end
                PH_CC_ESC:
                begin
                    if (is_control(c)) begin cont = 1'b1; phase_next = PH_CC_CLOSE; end
                    else if (c == CH_X_LO)
                    begin
                        cont = 1'b1; digit_next = 2'd0; phase_next = PH_CC_HEX;
                    end
                    else if (is_octal(c))
                    begin
                        cont = 1'b1; digit_next = 2'd1; phase_next = PH_CC_OCT;
                    end
                    else emit = 1'b1;
                end
                PH_CC_HEX:
                begin
                    if (is_hex(c))
                    begin
                        cont = 1'b1;
                        digit_next = dig_inc;
                        if (dig_inc == 2'd2) phase_next = PH_CC_CLOSE;
                    end
                    else
                    begin
                        emit = 1'b1;
                        len  = (digit_reg != 2'd0 && c == CH_QUOTE) ? now_len : '0;
                    end
                end
                PH_CC_OCT:
                begin
                    if (is_octal(c))
                    begin
                        cont = 1'b1;
                        digit_next = dig_inc;
                        if (dig_inc == 2'd3) phase_next = PH_CC_CLOSE;
                    end
                    else
                    begin
                        emit = 1'b1;
                        len  = (c == CH_QUOTE) ? now_len : '0;
                    end
                end
                PH_CC_CLOSE:
                begin
                    emit = 1'b1;
                    len  = (c == CH_QUOTE) ? now_len : '0;
                end
                PH_HX_X:
                begin
                    if (c == CH_X_LO || c == CH_X_UP) begin cont = 1'b1; phase_next = PH_HX_D; end
                    else emit = 1'b1;
                end
                PH_HX_D:
                begin
                    if (is_hex(c)) begin cont = 1'b1; phase_next = PH_HX_RUN; end
                    else emit = 1'b1;
                end
                PH_HX_RUN:
                begin
                    if (is_hex(c)) cont = 1'b1;
                    else begin emit = 1'b1; len = prev_len; end
                end
                PH_OC_D:
                begin
                    if (is_octal(c)) begin cont = 1'b1; phase_next = PH_OC_RUN; end
                    else emit = 1'b1;
                end
                PH_OC_RUN:
                begin
                    if (is_octal(c)) cont = 1'b1;
                    else begin emit = 1'b1; len = prev_len; end
                end
                PH_SE_ESC:
                begin
                    if (is_control(c)) begin emit = 1'b1; len = now_len; end
                    else if (c == CH_X_LO)
                    begin
                        cont = 1'b1; digit_next = 2'd0; phase_next = PH_SE_HEX;
                    end
                    else if (is_octal(c))
                    begin
                        cont = 1'b1; digit_next = 2'd1; phase_next = PH_SE_OCT;
                    end
                    else emit = 1'b1;
                end
                PH_SE_HEX:
                begin
                    if (is_hex(c))
                    begin
                        digit_next = dig_inc;
                        if (dig_inc == 2'd2) begin emit = 1'b1; len = now_len; end
                        else cont = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                        len  = (digit_reg == 2'd0) ? '0 : prev_len;
                    end
                end
                PH_SE_OCT:
                begin
                    if (is_octal(c))
                    begin
                        digit_next = dig_inc;
                        if (dig_inc == 2'd3) begin emit = 1'b1; len = now_len; end
                        else cont = 1'b1;
                    end
                    else begin emit = 1'b1; len = prev_len; end
                end
                PH_RANGE:
                begin
                    if (c == char_two_reg) begin emit = 1'b1; len = now_len; end
                    else cont = 1'b1;
                end
                default: emit = 1'b1;
            endcase
        end

        // attempt cut short by end of text
        if (cont && text.ends_text)
        begin
            emit = 1'b1;
            case (phase_next)
                PH_IDENT, PH_SPACE, PH_INT, PH_FL_EXP, PH_HX_RUN, PH_OC_RUN, PH_SE_OCT:
                    len = scanned_next;
                PH_FL_FRAC: len = (scanned_next == LEN_W'(1)) ? '0 : scanned_next;
                PH_FL_E, PH_FL_SIGN: len = acc_next;
                PH_SE_HEX: len = (digit_next == 2'd0) ? '0 : scanned_next;
                default: len = '0;
            endcase
        end

        if (emit)
        begin
            phase_next   = PH_IDLE;
            decided_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_kind_reg <= RK_CHAR;
            char_one_reg  <= '0;
            char_two_reg  <= '0;
            first_ns_reg  <= 1'b0;
            req_col_reg   <= '1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_RULE_KIND:  rule_kind_reg <= cfg_wr_data[KIND_W-1:0];
                REG_CHAR_ONE:   char_one_reg  <= cfg_wr_data[CHAR_W-1:0];
                REG_CHAR_TWO:   char_two_reg  <= cfg_wr_data[CHAR_W-1:0];
                REG_FIRST_NS:   first_ns_reg  <= cfg_wr_data[0];
                REG_REQ_COLUMN: req_col_reg   <= cfg_wr_data[RCOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            scanned_reg <= '0;
            acc_reg     <= '0;
            digit_reg   <= '0;
            decided_reg <= 1'b1;
        end
        else if (in_acc)
        begin
            phase_reg   <= phase_next;
            scanned_reg <= scanned_next;
            acc_reg     <= acc_next;
            digit_reg   <= digit_next;
            decided_reg <= decided_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && emit)
        begin
            out_len_reg     <= len;
            out_matched_reg <= (len != '0);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.match_length = out_len_reg;
    assign result.matched      = out_matched_reg;

    a_matched_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_matched_reg == (out_len_reg != '0)))
        else $error("matched flag disagrees with length");

    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_len_reg <= LEN_CAP_V))
        else $error("length above cap");

    a_decided_idle: assert property (@(posedge clk) disable iff (!rst_n)
        decided_reg |-> (phase_reg == PH_IDLE))
        else $error("decided with active phase");

    a_scan_cap: assert property (@(posedge clk) disable iff (!rst_n)
        scanned_reg <= LEN_CAP_V)
        else $error("scan count above cap");

    a_start_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && text.starts_match) |=> (!decided_reg || out_valid_reg))
        else $error("start item neither pending nor reported");

endmodule

`default_nettype wire
